@@ sv/bsc_pkg.sv @@
package bsc_pkg;

  localparam int NUM_SYM   = 8;
  localparam int SIDE      = 5;
  localparam int CELLS     = SIDE * SIDE;
  localparam int CELL_W    = 2;
  localparam int BOARD_W   = CELLS * CELL_W;
  localparam int SYM_W     = $clog2(NUM_SYM);
  localparam int COORD_W   = 3;
  localparam int POINT_W   = 4;

  typedef logic [BOARD_W-1:0]   board_t;
  typedef logic [SYM_W-1:0]     sym_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [POINT_W-1:0]   point_t;

  typedef enum logic [1:0] {
    KIND_CANON   = 2'd0,
    KIND_XFORM   = 2'd1,
    KIND_POINT   = 2'd2,
    KIND_INVERSE = 2'd3
  } kind_t;

  localparam coord_t EDGE_MAX = coord_t'(SIDE - 1);

  // Map an on-board point: optional mirror of x, then quarter turns
  // (x,y) -> (4-y,x). Returns {x, y}.
  function automatic logic [2*COORD_W-1:0] map_xy(sym_t sym, coord_t x, coord_t y);
    coord_t mx;
    coord_t ox;
    coord_t oy;
    mx = sym[2] ? (EDGE_MAX - x) : x;
    unique case (sym[1:0])
      2'd0: begin
        ox = mx;
        oy = y;
      end
      2'd1: begin
        ox = EDGE_MAX - y;
        oy = mx;
      end
      2'd2: begin
        ox = EDGE_MAX - mx;
        oy = EDGE_MAX - y;
      end
      2'd3: begin
        ox = y;
        oy = EDGE_MAX - mx;
      end
    endcase
    return {ox, oy};
  endfunction

  // Reflections undo themselves; a pure rotation is undone by the
  // complementary rotation.
  function automatic sym_t inv_sym(sym_t sym);
    sym_t r;
    if (sym[2]) begin
      r = sym;
    end else begin
      r = {1'b0, 2'(2'd0 - sym[1:0])};
    end
    return r;
  endfunction

endpackage

@@ sv/bsc_perm.sv @@
module bsc_perm (
  input  bsc_pkg::board_t board_i,
  output bsc_pkg::board_t perm_o [bsc_pkg::NUM_SYM]
);
  import bsc_pkg::*;

  // Each symmetry is a fixed rewiring of the cells.
  for (genvar s = 0; s < NUM_SYM; s++) begin : g_sym
    for (genvar x = 0; x < SIDE; x++) begin : g_x
      for (genvar y = 0; y < SIDE; y++) begin : g_y
        localparam logic [2*COORD_W-1:0] XY = map_xy(sym_t'(s), coord_t'(x), coord_t'(y));
        localparam int DST = SIDE * int'(XY[2*COORD_W-1:COORD_W]) + int'(XY[COORD_W-1:0]);
        localparam int SRC = SIDE * x + y;
        assign perm_o[s][CELL_W*DST +: CELL_W] = board_i[CELL_W*SRC +: CELL_W];
      end
    end
  end

endmodule

@@ sv/bsc_min8.sv @@
module bsc_min8 (
  input  bsc_pkg::board_t cand_i [bsc_pkg::NUM_SYM],
  output bsc_pkg::board_t min_o,
  output bsc_pkg::sym_t   idx_o
);
  import bsc_pkg::*;

  board_t l1_b [4];
  sym_t   l1_i [4];
  board_t l2_b [2];
  sym_t   l2_i [2];

  // Left side carries the lower codes: keep it unless right is strictly less.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (cand_i[2*i+1] < cand_i[2*i]) begin
        l1_b[i] = cand_i[2*i+1];
        l1_i[i] = sym_t'(2*i+1);
      end else begin
        l1_b[i] = cand_i[2*i];
        l1_i[i] = sym_t'(2*i);
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (l1_b[2*i+1] < l1_b[2*i]) begin
        l2_b[i] = l1_b[2*i+1];
        l2_i[i] = l1_i[2*i+1];
      end else begin
        l2_b[i] = l1_b[2*i];
        l2_i[i] = l1_i[2*i];
      end
    end
    if (l2_b[1] < l2_b[0]) begin
      min_o = l2_b[1];
      idx_o = l2_i[1];
    end else begin
      min_o = l2_b[0];
      idx_o = l2_i[0];
    end
  end

endmodule

@@ sv/board_symmetry_canonicalizer.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// in_      | in_valid / in_stall  | in_kind, in_board_in, in_sym_in, in_point_x/y
// out_     | out_valid / out_stall| out_board_out, out_sym_out, out_x, out_y
//
// One request per cycle sustained while out_stall is low. The request register
// feeds the cell rewiring and a three-level compare tree, which load the result
// register when it is free; the result register drives out_valid.
// rst_n is synchronous, active low, and empties both registers.
// A stalled result holds; the request register keeps taking requests while the
// result register is free or being drained.
module board_symmetry_canonicalizer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bsc_pkg::kind_t   in_kind,
  input  bsc_pkg::board_t  in_board_in,
  input  bsc_pkg::sym_t    in_sym_in,
  input  bsc_pkg::point_t  in_point_x,
  input  bsc_pkg::point_t  in_point_y,
  output logic             out_valid,
  input  logic             out_stall,
  output bsc_pkg::board_t  out_board_out,
  output bsc_pkg::sym_t    out_sym_out,
  output bsc_pkg::point_t  out_x,
  output bsc_pkg::point_t  out_y
);
  import bsc_pkg::*;

  // request register
  logic   req_vld_r, req_vld_nxt;
  kind_t  kind_r;
  board_t board_r;
  sym_t   sym_r;
  point_t px_r;
  point_t py_r;

  // result register
  logic   out_vld_r, out_vld_nxt;
  board_t res_board_r, res_board_nxt;
  sym_t   res_sym_r, res_sym_nxt;
  point_t res_x_r, res_x_nxt;
  point_t res_y_r, res_y_nxt;

  logic   out_adv;
  logic   req_ready;
  logic   in_acc;

  board_t perm [NUM_SYM];
  board_t min_board;
  sym_t   min_idx;
  logic   on_board;
  logic [2*COORD_W-1:0] pt_map;

  // probe point for the inverse check
  logic [2*COORD_W-1:0] chk_fwd;
  logic [2*COORD_W-1:0] chk_back;

  // Result register frees up when empty or when its result is taken.
  assign out_adv   = !out_vld_r || !out_stall;
  assign req_ready = !req_vld_r || out_adv;
  assign in_acc    = in_valid && req_ready;
  assign in_stall  = !req_ready;

  always_comb begin
    if (in_acc) begin
      req_vld_nxt = 1'b1;
    end else if (out_adv) begin
      req_vld_nxt = 1'b0;
    end else begin
      req_vld_nxt = req_vld_r;
    end
    out_vld_nxt = out_adv ? req_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Hold the request while the result side is blocked.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_kind;
      board_r <= in_board_in;
      sym_r   <= in_sym_in;
      px_r    <= in_point_x;
      py_r    <= in_point_y;
    end
  end

  bsc_perm u_perm (
    .board_i (board_r),
    .perm_o  (perm)
  );

  bsc_min8 u_min8 (
    .cand_i (perm),
    .min_o  (min_board),
    .idx_o  (min_idx)
  );

  // Negative coordinates read as large unsigned values, so one compare per
  // axis rejects both sides of the board.
  assign on_board = (px_r <= point_t'(EDGE_MAX)) && (py_r <= point_t'(EDGE_MAX));
  assign pt_map   = map_xy(sym_r, px_r[COORD_W-1:0], py_r[COORD_W-1:0]);

  // Unused result fields read as zero for each kind.
  always_comb begin
    res_board_nxt = '0;
    res_sym_nxt   = '0;
    res_x_nxt     = '0;
    res_y_nxt     = '0;
    unique case (kind_r)
      KIND_CANON: begin
        res_board_nxt = min_board;
        res_sym_nxt   = min_idx;
      end
      KIND_XFORM: begin
        res_board_nxt = perm[sym_r];
      end
      KIND_POINT: begin
        if (on_board) begin
          res_x_nxt = {1'b0, pt_map[2*COORD_W-1:COORD_W]};
          res_y_nxt = {1'b0, pt_map[COORD_W-1:0]};
        end else begin
          res_x_nxt = px_r;
          res_y_nxt = py_r;
        end
      end
      KIND_INVERSE: begin
        res_sym_nxt = inv_sym(sym_r);
      end
    endcase
  end

  // Advance the result only when a request is waiting and the slot is free.
  always_ff @(posedge clk) begin
    if (out_adv && req_vld_r) begin
      res_board_r <= res_board_nxt;
      res_sym_r   <= res_sym_nxt;
      res_x_r     <= res_x_nxt;
      res_y_r     <= res_y_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_board_out = res_board_r;
  assign out_sym_out   = res_sym_r;
  assign out_x         = res_x_r;
  assign out_y         = res_y_r;

  // Send a probe point out by the request code and back by its inverse.
  assign chk_fwd  = map_xy(sym_r, coord_t'(0), coord_t'(1));
  assign chk_back = map_xy(res_sym_nxt, chk_fwd[2*COORD_W-1:COORD_W], chk_fwd[COORD_W-1:0]);

  // The inverse code must bring a mapped point back home.
  a_inv_undoes: assert property (@(posedge clk) disable iff (!rst_n)
    (req_vld_r && kind_r == KIND_INVERSE) |->
      (chk_back == {coord_t'(0), coord_t'(1)}))
    else $error("inverse symmetry does not undo the request code");

  // The canonical board is never above the identity board.
  a_canon_le: assert property (@(posedge clk) disable iff (!rst_n)
    (req_vld_r && kind_r == KIND_CANON) |-> (min_board <= board_r))
    else $error("canonical board exceeds the input board");

  // A blocked request stays put.
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (req_vld_r && !out_adv) |=> (req_vld_r && $stable(board_r) && $stable(kind_r)))
    else $error("request lost while result side was blocked");

  // An accepted request is loaded into the request register.
  a_req_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> req_vld_r)
    else $error("accepted request did not load");

endmodule
